// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/c16s_pkg.sv =====
// Types, codes and helper functions for the 16-bit processor step engine.
`timescale 1ns / 1ps

package c16s_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;
  localparam logic [1:0] KIND_RESET = 2'd3;

  localparam logic [3:0] OP_ADD  = 4'h0;
  localparam logic [3:0] OP_SUB  = 4'h1;
  localparam logic [3:0] OP_SRA  = 4'h2;
  localparam logic [3:0] OP_SLL  = 4'h3;
  localparam logic [3:0] OP_AND  = 4'h4;
  localparam logic [3:0] OP_OR   = 4'h5;
  localparam logic [3:0] OP_XOR  = 4'h6;
  localparam logic [3:0] OP_NAND = 4'h7;
  localparam logic [3:0] OP_LW   = 4'h8;
  localparam logic [3:0] OP_SW   = 4'h9;
  localparam logic [3:0] OP_ADDI = 4'ha;
  localparam logic [3:0] OP_LUI  = 4'hb;
  localparam logic [3:0] OP_MATH = 4'hc;
  localparam logic [3:0] OP_INT  = 4'hd;
  localparam logic [3:0] OP_JMP  = 4'he;
  localparam logic [3:0] OP_FPT  = 4'hf;

  localparam int ALU_OP_BITS = 3;
  localparam logic [ALU_OP_BITS-1:0] ALU_ADD  = 3'd0;
  localparam logic [ALU_OP_BITS-1:0] ALU_SUB  = 3'd1;
  localparam logic [ALU_OP_BITS-1:0] ALU_SRA  = 3'd2;
  localparam logic [ALU_OP_BITS-1:0] ALU_SLL  = 3'd3;
  localparam logic [ALU_OP_BITS-1:0] ALU_AND  = 3'd4;
  localparam logic [ALU_OP_BITS-1:0] ALU_OR   = 3'd5;
  localparam logic [ALU_OP_BITS-1:0] ALU_XOR  = 3'd6;
  localparam logic [ALU_OP_BITS-1:0] ALU_NAND = 3'd7;

  localparam logic [3:0] REG_R0 = 4'd0;
  localparam logic [3:0] REG_PC = 4'd1;

  localparam logic [2:0] FLAG_NEG  = 3'b001;
  localparam logic [2:0] FLAG_ZERO = 3'b010;
  localparam logic [2:0] FLAG_POS  = 3'b100;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [15:0] write_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_word;
    logic [15:0] program_counter;
    logic [2:0]  flag_bits;
    logic        halted;
    logic        print_request;
    logic        unimplemented;
  } out_item_t;

  typedef struct packed {
    logic        clr;
    logic        we;
    logic [3:0]  waddr;
    logic [15:0] wdata;
    logic [3:0]  raddr_a;
    logic [3:0]  raddr_b;
  } rf_req_t;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    logic [2:0] f;
    if (v == 16'h0000) begin
      f = FLAG_ZERO;
    end else if (v[15]) begin
      f = FLAG_NEG;
    end else begin
      f = FLAG_POS;
    end
    return f;
  endfunction

endpackage

// ===== src/c16s_alu.sv =====
// Shared 16-bit arithmetic, logic and shift unit.
`timescale 1ns / 1ps

module c16s_alu (
  input  logic [c16s_pkg::ALU_OP_BITS-1:0] op,
  input  logic [15:0]                      a,
  input  logic [15:0]                      b,
  output logic [15:0]                      res
);

  always_comb begin
    case (op)
      c16s_pkg::ALU_ADD:  res = a + b;
      c16s_pkg::ALU_SUB:  res = a - b;
      c16s_pkg::ALU_SRA:  res = $unsigned($signed(a) >>> b[3:0]);
      c16s_pkg::ALU_SLL:  res = a << b[3:0];
      c16s_pkg::ALU_AND:  res = a & b;
      c16s_pkg::ALU_OR:   res = a | b;
      c16s_pkg::ALU_XOR:  res = a ^ b;
      c16s_pkg::ALU_NAND: res = ~(a & b);
      default:            res = a + b;
    endcase
  end

endmodule

// ===== src/c16s_rf.sv =====
// Register file: general registers with valid bits, zero register and PC read-through.
`timescale 1ns / 1ps

module c16s_rf (
  input  logic              clk,
  input  logic              rst_n,
  input  c16s_pkg::rf_req_t req,
  input  logic [15:0]       pc,
  output logic [15:0]       rdata_a,
  output logic [15:0]       rdata_b
);

  logic [15:0] mem [16];
  logic [15:0] valid_r;
  logic [15:0] data_a_r;
  logic [15:0] data_b_r;
  logic        pc_a_r;
  logic        pc_b_r;
  logic        zero_a_r;
  logic        zero_b_r;
  logic        wr_ok;

  assign wr_ok = req.we && (req.waddr != c16s_pkg::REG_R0) && (req.waddr != c16s_pkg::REG_PC);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      valid_r <= '0;
    end else if (wr_ok) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    data_a_r <= mem[req.raddr_a];
    data_b_r <= mem[req.raddr_b];
    pc_a_r   <= (req.raddr_a == c16s_pkg::REG_PC);
    pc_b_r   <= (req.raddr_b == c16s_pkg::REG_PC);
    zero_a_r <= (req.raddr_a == c16s_pkg::REG_R0) || !valid_r[req.raddr_a];
    zero_b_r <= (req.raddr_b == c16s_pkg::REG_R0) || !valid_r[req.raddr_b];
  end

  assign rdata_a = pc_a_r ? pc : (zero_a_r ? 16'h0000 : data_a_r);
  assign rdata_b = pc_b_r ? pc : (zero_b_r ? 16'h0000 : data_b_r);

endmodule

// ===== src/c16s_mem.sv =====
// Single-port word memory with registered read data.
`timescale 1ns / 1ps

module c16s_mem #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [15:0]          wdata,
  output logic [15:0]          rdata
);

  logic [15:0] mem [2**ADDR_BITS];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/custom16_cpu_step_top.sv =====
// Top level of the 16-bit processor step engine: sequencer, state and result register.
//
// Usage: one command per input transaction on in_valid/in_ready with payload in_data:
// write a memory word, read a memory word, execute one instruction at PC, or reset
// the registers, flags and halt mark (memory is kept). Every command yields exactly
// one result transaction on out_valid/out_ready carrying the read word, PC, flags,
// halt mark and the print and unimplemented indications of that command.
// Write and reset go from idle straight to the done state, a read passes through the
// read-wait state, and a step while halted goes straight to done; a halt instruction
// leaves execute for done without the PC update. in_ready rises together with
// out_valid, as the sequencer leaves the done state for idle.
// The sequencer handles one command at a time; in_ready is high only while it is
// idle. A step walks fetch, execute, optional load, PC update, with one shared
// ALU doing the operation, the data address, the immediate add and the PC update,
// and the single memory port carrying the fetch and the data access.
// Reset clears PC, flags, halt mark and the register valid bits; memory content is
// undefined until written. When the receiver stalls, the result holds in the output
// register and the sequencer waits with the next result until it is taken.
`timescale 1ns / 1ps

module custom16_cpu_step_top #(
  parameter int ADDR_BITS = 16
) (
  input  logic                in_valid,
  output logic                in_ready,
  input  c16s_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output c16s_pkg::out_item_t out_data,
  input  logic                clk,
  input  logic                rst_n
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_PCUPD  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic        halt_r, halt_nxt;
  logic [15:0] ir_r, ir_nxt;
  logic [15:0] rword_r, rword_nxt;
  logic        print_r, print_nxt;
  logic        unimpl_r, unimpl_nxt;
  logic        out_valid_r, out_valid_nxt;
  c16s_pkg::out_item_t out_data_r, out_data_nxt;

  c16s_pkg::rf_req_t rf_req;
  logic [15:0] rdata_a;
  logic [15:0] rdata_b;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [15:0]          mem_wdata;
  logic [15:0]          mem_rdata;

  logic [c16s_pkg::ALU_OP_BITS-1:0] alu_op;
  logic [15:0] alu_a;
  logic [15:0] alu_b;
  logic [15:0] alu_res;

  logic [3:0]  op;
  logic [3:0]  rd;
  logic [3:0]  ra;
  logic [3:0]  rb;
  logic [15:0] off4;
  logic [15:0] imm;
  logic [15:0] jimm;
  logic        jump_taken;
  logic        suppress;
  logic        wb_en;
  logic [15:0] wb_val;

  assign op   = ir_r[3:0];
  assign rd   = ir_r[7:4];
  assign ra   = ir_r[11:8];
  assign rb   = ir_r[15:12];
  assign off4 = {{12{rb[3]}}, rb};
  assign imm  = {{8{ra[3]}}, ra, rb};
  assign jimm = {{8{rd[3]}}, rd, ra};

  assign jump_taken = (op == c16s_pkg::OP_JMP) && !rb[3] && ((flags_r & rb[2:0]) != 3'b000);
  assign suppress = (rd == c16s_pkg::REG_PC) &&
                    ((op inside {[c16s_pkg::OP_ADD:c16s_pkg::OP_LW],
                                 c16s_pkg::OP_ADDI, c16s_pkg::OP_LUI}) ||
                     ((op == c16s_pkg::OP_JMP) && rb[3]));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  c16s_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  c16s_rf u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (rf_req),
    .pc      (pc_r),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  c16s_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    flags_nxt     = flags_r;
    halt_nxt      = halt_r;
    ir_nxt        = ir_r;
    rword_nxt     = rword_r;
    print_nxt     = print_r;
    unimpl_nxt    = unimpl_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    rf_req         = '0;
    rf_req.raddr_a = mem_rdata[11:8];
    rf_req.raddr_b = ((mem_rdata[3:0] == c16s_pkg::OP_SW) ||
                      (mem_rdata[3:0] == c16s_pkg::OP_ADDI)) ? mem_rdata[7:4]
                                                              : mem_rdata[15:12];

    mem_we    = 1'b0;
    mem_addr  = pc_r[ADDR_BITS-1:0];
    mem_wdata = in_data.write_word;

    alu_op = c16s_pkg::ALU_ADD;
    alu_a  = rdata_a;
    alu_b  = rdata_b;
    wb_en  = 1'b0;
    wb_val = alu_res;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rword_nxt  = 16'h0000;
          print_nxt  = 1'b0;
          unimpl_nxt = 1'b0;
          mem_addr   = in_data.address[ADDR_BITS-1:0];
          case (in_data.kind)
            c16s_pkg::KIND_WRITE: begin
              mem_we    = 1'b1;
              state_nxt = S_DONE;
            end
            c16s_pkg::KIND_READ: begin
              state_nxt = S_RDWAIT;
            end
            c16s_pkg::KIND_STEP: begin
              mem_addr  = pc_r[ADDR_BITS-1:0];
              state_nxt = halt_r ? S_DONE : S_FETCH;
            end
            default: begin
              rf_req.clr = 1'b1;
              pc_nxt     = 16'h0000;
              flags_nxt  = 3'b000;
              halt_nxt   = 1'b0;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        rword_nxt = mem_rdata;
        state_nxt = S_DONE;
      end
      S_FETCH: begin
        ir_nxt    = mem_rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_PCUPD;
        case (op)
          c16s_pkg::OP_ADD, c16s_pkg::OP_SUB, c16s_pkg::OP_SRA, c16s_pkg::OP_SLL,
          c16s_pkg::OP_AND, c16s_pkg::OP_OR, c16s_pkg::OP_XOR, c16s_pkg::OP_NAND: begin
            alu_op    = op[c16s_pkg::ALU_OP_BITS-1:0];
            wb_en     = 1'b1;
            flags_nxt = c16s_pkg::flags_of(alu_res);
          end
          c16s_pkg::OP_LW: begin
            alu_b     = off4;
            mem_addr  = alu_res[ADDR_BITS-1:0];
            state_nxt = S_LOAD;
          end
          c16s_pkg::OP_SW: begin
            alu_b     = off4;
            mem_addr  = alu_res[ADDR_BITS-1:0];
            mem_we    = 1'b1;
            mem_wdata = rdata_b;
          end
          c16s_pkg::OP_ADDI: begin
            alu_a = rdata_b;
            alu_b = imm;
            wb_en = 1'b1;
          end
          c16s_pkg::OP_LUI: begin
            wb_val = {ra, rb, 8'h00};
            wb_en  = 1'b1;
          end
          c16s_pkg::OP_INT: begin
            if (rd == c16s_pkg::REG_R0) begin
              halt_nxt  = 1'b1;
              state_nxt = S_DONE;
            end else if ((rd == c16s_pkg::REG_PC) && (rb == 4'd1)) begin
              print_nxt = 1'b1;
            end
          end
          c16s_pkg::OP_JMP: begin
            if (rb[3]) begin
              unimpl_nxt = 1'b1;
            end
          end
          default: begin
            unimpl_nxt = 1'b1;
          end
        endcase
      end
      S_LOAD: begin
        wb_val    = mem_rdata;
        wb_en     = 1'b1;
        state_nxt = S_PCUPD;
      end
      S_PCUPD: begin
        alu_a = pc_r;
        alu_b = jump_taken ? jimm : 16'h0001;
        if (!suppress) begin
          pc_nxt = alu_res;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.read_word       = rword_r;
          out_data_nxt.program_counter = pc_r;
          out_data_nxt.flag_bits       = flags_r;
          out_data_nxt.halted          = halt_r;
          out_data_nxt.print_request   = print_r;
          out_data_nxt.unimplemented   = unimpl_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (wb_en) begin
      if (rd == c16s_pkg::REG_PC) begin
        pc_nxt = wb_val;
      end else begin
        rf_req.we    = 1'b1;
        rf_req.waddr = rd;
        rf_req.wdata = wb_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= 16'h0000;
      flags_r     <= 3'b000;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      flags_r     <= flags_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ir_r       <= ir_nxt;
    rword_r    <= rword_nxt;
    print_r    <= print_nxt;
    unimpl_r   <= unimpl_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== src/c16s_checker.sv =====
// Port-level checker for the processor step engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module c16s_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input c16s_pkg::out_item_t out_data
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second transaction accepted while busy")
  `ASSERT_IMPL(a_flags_onehot0, out_valid, $onehot0(out_data.flag_bits), "more than one flag set")
  `ASSERT_IMPL(a_step_only, out_valid && (out_data.print_request || out_data.unimplemented), (out_data.read_word == 16'h0000) && !out_data.halted && !(out_data.print_request && out_data.unimplemented), "step indication inconsistent with result")

endmodule

bind custom16_cpu_step_top c16s_checker u_c16s_checker (.*);
